>>> src/rsmt_pkg.sv
package rsmt_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_REPLY   = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_GRANTED  = 4'd0,
		ST_FULL     = 4'd1,
		ST_MATCHED  = 4'd2,
		ST_UNKNOWN  = 4'd3,
		ST_DUP      = 4'd4,
		ST_RETRY    = 4'd5,
		ST_GAVE_UP  = 4'd6,
		ST_RELEASED = 4'd7,
		ST_NOT_BUSY = 4'd8
	} status_t;

	localparam logic [2:0] CFG_INIT_TO = 3'd0;
	localparam logic [2:0] CFG_STEP    = 3'd1;
	localparam logic [2:0] CFG_DOUBLE  = 3'd2;
	localparam logic [2:0] CFG_CAP     = 3'd3;
	localparam logic [2:0] CFG_LIMIT   = 3'd4;

	typedef struct packed {
		logic [31:0] initial_timeout;
		logic [31:0] linear_step;
		logic        doubling_mode;
		logic [31:0] timeout_cap;
		logic [7:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  slot;
		logic [15:0] length;
		logic [31:0] timeout;
	} result_t;

	function automatic logic [31:0] backoff(input logic [31:0] t, input cfg_t c);
		logic [32:0] s;
		logic [31:0] r;
		if (c.doubling_mode) begin
			s = {t, 1'b0};
		end else begin
			s = {1'b0, t} + {1'b0, c.linear_step};
		end
		r = s[32] ? 32'hFFFF_FFFF : s[31:0];
		if (c.timeout_cap != 32'd0 && r >= c.timeout_cap) begin
			r = c.timeout_cap;
		end
		return r;
	endfunction

endpackage

>>> src/rsmt_cfg.sv
module rsmt_cfg
	import rsmt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [2:0]  idx,
	input  logic [31:0] wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (we) begin
			unique case (idx)
				CFG_INIT_TO: cfg_q.initial_timeout <= wdata;
				CFG_STEP:    cfg_q.linear_step <= wdata;
				CFG_DOUBLE:  cfg_q.doubling_mode <= wdata[0];
				CFG_CAP:     cfg_q.timeout_cap <= wdata;
				CFG_LIMIT:   cfg_q.retry_limit <= wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/request_slot_match_table_unit.sv
// Request slot match table.
// Input stream s_axis: one transaction per operation (allocate, reply, timeout,
// release). Output stream m_axis: exactly one result transaction per input.
// Configuration: cfg_we/cfg_idx/cfg_wdata write registers 0..4 at a clock edge;
// write only while idle.
// Slot state sits in one synchronous memory word per slot (id, length,
// timeout, retry count, answered, queue links) with a registered read; a
// sequencer reads, modifies and writes back one word at a time.
// Full, reply on an empty queue and slot not busy go straight to the result; allocate
// writes the slot word and, when the queue is not empty, links the old tail; retry
// writes the slot word; release and gave up also relink each queue neighbor; reply
// walks the queue up to SLOTS entries, each hop waiting for the memory read.
// One operation is in flight at a time; s_axis_tready is high while the sequencer
// is idle, so the next transaction is taken at the earliest in the cycle after a result.
// Reset: all slots free, free stack 0..SLOTS-1 with slot 0 on top, queue empty,
// registers zero. Busy bits and free links live in flip-flops.
// When m_axis_tready is low the result is held in the output register; the next
// operation runs to its end and waits there until the register is free.
module request_slot_match_table_unit
	import rsmt_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[1:0], request_id[33:2], buffer_length[49:34], slot_index[53:50]
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[3:0], result_slot[7:4], result_length[23:8], result_timeout[55:24]
	output logic [55:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	localparam int AW = $clog2(SLOTS);
	localparam int LW = AW + 1;
	localparam logic [LW-1:0] NONE = LW'(SLOTS);

	typedef struct packed {
		logic [31:0]   rid;
		logic [15:0]   len;
		logic [31:0]   tmo;
		logic [7:0]    cnt;
		logic          ans;
		logic [LW-1:0] nxt;
		logic [LW-1:0] prv;
	} ent_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD    = 7'b0000010,
		S_EXEC  = 7'b0000100,
		S_LINK  = 7'b0001000,
		S_ULP   = 7'b0010000,
		S_ULN   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	cfg_t cfg;
	rsmt_cfg u_cfg (.clk, .arst_n, .we(cfg_we), .idx(cfg_idx), .wdata(cfg_wdata), .cfg);

	ent_t          mem [SLOTS];
	ent_t          rd_q;
	logic          re;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	ent_t          wdat;

	state_t        st_q;
	logic [SLOTS-1:0] busy_q;
	logic [LW-1:0] flink_q [SLOTS];
	logic [LW-1:0] ftop_q, head_q, tail_q;
	op_t           op_q;
	logic [31:0]   rid_q;
	logic [15:0]   len_q;
	logic [3:0]    idx_q;
	logic [LW-1:0] cur_q, p_q, n_q;
	logic [4+AW:0] steps_q;
	result_t       res_q;
	result_t       out_q;
	logic          ov_q;
	logic          out_ld;

	logic          acc;
	logic [AW-1:0] cur_a, ia;
	logic [31:0]   nt;
	logic [7:0]    nc;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {out_q.timeout, out_q.length, out_q.slot, 4'(out_q.status)};
	assign out_ld = (st_q == S_OUT) && (!ov_q || m_axis_tready);
	assign cur_a = cur_q[AW-1:0];
	assign ia = AW'(idx_q);
	assign nt = backoff(rd_q.tmo, cfg);
	assign nc = rd_q.cnt + 8'd1;

	always_comb begin
		re = 1'b0;
		raddr = cur_a;
		we = 1'b0;
		waddr = cur_a;
		wdat = rd_q;
		unique case (st_q)
			S_RD: begin
				re = 1'b1;
			end
			S_EXEC: begin
				unique case (op_q)
					OP_ALLOC: begin
						we = 1'b1;
						wdat = '{rid: rid_q, len: len_q, tmo: cfg.initial_timeout,
							cnt: 8'd0, ans: 1'b0, nxt: NONE, prv: tail_q};
					end
					OP_REPLY: begin
						if (rd_q.rid == rid_q && !rd_q.ans) begin
							we = 1'b1;
							wdat.ans = 1'b1;
						end
					end
					OP_TIMEOUT: begin
						we = 1'b1;
						wdat.tmo = nt;
						if (cfg.retry_limit != 8'd0) wdat.cnt = nc;
					end
					default: ;
				endcase
			end
			S_LINK: begin
				re = 1'b1;
				raddr = p_q[AW-1:0];
			end
			S_ULP: begin
				re = 1'b1;
				raddr = p_q[AW-1:0];
			end
			S_ULN: begin
				re = 1'b1;
				raddr = n_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// second-phase writes happen in the cycle after the neighbor read
	logic          wb_q;
	logic          wbn_q;
	logic [AW-1:0] wba_q;
	logic [LW-1:0] wbv_q;
	ent_t          wbd;
	logic          we2;

	always_comb begin
		wbd = rd_q;
		if (wbn_q) wbd.nxt = wbv_q; else wbd.prv = wbv_q;
		we2 = wb_q;
	end

	// memory write mux: second-phase writes never coincide with S_EXEC writes
	ent_t          mw_d;
	logic [AW-1:0] mw_a;
	logic          mw_e;
	assign mw_e = we || we2;
	assign mw_a = we2 ? wba_q : waddr;
	assign mw_d = we2 ? wbd : wdat;

	always_ff @(posedge clk) begin
		if (mw_e) mem[mw_a] <= mw_d;
		if (re) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			busy_q <= '0;
			for (int i = 0; i < SLOTS; i++) flink_q[i] <= LW'(i + 1);
			ftop_q <= '0;
			head_q <= NONE;
			tail_q <= NONE;
			ov_q <= 1'b0;
			out_q <= '0;
			wb_q <= 1'b0;
		end else begin
			wb_q <= (st_q == S_LINK) || (st_q == S_ULP) || (st_q == S_ULN);
			ov_q <= out_ld || (ov_q && !m_axis_tready);
			if (out_ld) out_q <= res_q;
			unique case (st_q)
				S_IDLE: begin
					if (acc) begin
						op_q <= op_t'(s_axis_tdata[1:0]);
						rid_q <= s_axis_tdata[33:2];
						len_q <= s_axis_tdata[49:34];
						idx_q <= s_axis_tdata[53:50];
						steps_q <= '0;
						unique case (op_t'(s_axis_tdata[1:0]))
							OP_ALLOC: begin
								if (ftop_q == NONE) begin
									res_q <= '{ST_FULL, 4'd0, 16'd0, 32'd0};
									st_q <= S_OUT;
								end else begin
									res_q <= '0;
									cur_q <= ftop_q;
									st_q <= S_EXEC;
								end
							end
							OP_REPLY: begin
								cur_q <= head_q;
								st_q <= (head_q == NONE) ? S_OUT : S_RD;
								res_q <= '{ST_UNKNOWN, 4'd0, 16'd0, 32'd0};
							end
							default: begin
								cur_q <= LW'(s_axis_tdata[53:50]);
								if ({28'd0, s_axis_tdata[53:50]} < 32'(SLOTS)
									&& busy_q[AW'(s_axis_tdata[53:50])]) begin
									res_q <= '0;
									st_q <= S_RD;
								end else begin
									res_q <= '{ST_NOT_BUSY, 4'd0, 16'd0, 32'd0};
									st_q <= S_OUT;
								end
							end
						endcase
					end
				end
				S_RD: st_q <= S_EXEC;
				S_EXEC: begin
					unique case (op_q)
						OP_ALLOC: begin
							ftop_q <= flink_q[cur_a];
							busy_q[cur_a] <= 1'b1;
							tail_q <= cur_q;
							res_q.status <= ST_GRANTED;
							res_q.slot <= 4'(cur_q);
							res_q.timeout <= cfg.initial_timeout;
							if (tail_q == NONE) begin
								head_q <= cur_q;
								st_q <= S_OUT;
							end else begin
								p_q <= tail_q;
								st_q <= S_LINK;
							end
						end
						OP_REPLY: begin
							if (rd_q.rid == rid_q) begin
								res_q.slot <= 4'(cur_q);
								if (rd_q.ans) begin
									res_q.status <= ST_DUP;
								end else begin
									res_q.status <= ST_MATCHED;
									res_q.length <= rd_q.len;
								end
								st_q <= S_OUT;
							end else if (rd_q.nxt == NONE
								|| steps_q + 1'b1 >= (5 + AW)'(SLOTS)) begin
								st_q <= S_OUT;
							end else begin
								cur_q <= rd_q.nxt;
								steps_q <= steps_q + 1'b1;
								st_q <= S_RD;
							end
						end
						default: begin
							res_q.slot <= idx_q;
							p_q <= rd_q.prv;
							n_q <= rd_q.nxt;
							if (op_q == OP_TIMEOUT && !(cfg.retry_limit != 8'd0
								&& nc >= cfg.retry_limit)) begin
								res_q.status <= ST_RETRY;
								res_q.timeout <= nt;
								st_q <= S_OUT;
							end else begin
								res_q.status <= (op_q == OP_TIMEOUT) ? ST_GAVE_UP : ST_RELEASED;
								busy_q[ia] <= 1'b0;
								flink_q[ia] <= ftop_q;
								ftop_q <= LW'(idx_q);
								if (rd_q.prv == NONE) head_q <= rd_q.nxt;
								if (rd_q.nxt == NONE) tail_q <= rd_q.prv;
								st_q <= (rd_q.prv != NONE) ? S_ULP
									: (rd_q.nxt != NONE) ? S_ULN : S_OUT;
							end
						end
					endcase
				end
				S_LINK: begin
					wbn_q <= 1'b1;
					wba_q <= p_q[AW-1:0];
					wbv_q <= cur_q;
					st_q <= S_OUT;
				end
				S_ULP: begin
					wbn_q <= 1'b1;
					wba_q <= p_q[AW-1:0];
					wbv_q <= n_q;
					st_q <= (n_q != NONE) ? S_ULN : S_OUT;
				end
				S_ULN: begin
					wbn_q <= 1'b0;
					wba_q <= n_q[AW-1:0];
					wbv_q <= p_q;
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ld) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench
	import rsmt_pkg::*;
();

	localparam int NSLOT = 16;
	localparam logic [4:0] NONE = 5'd16;

	class slot_table_scoreboard;
		logic [31:0] init_to, step, cap;
		logic dbl;
		logic [7:0] limit;
		bit busy[NSLOT];
		logic [31:0] rid[NSLOT];
		bit answered[NSLOT];
		logic [15:0] len[NSLOT];
		logic [31:0] tmo[NSLOT];
		logic [7:0] retries[NSLOT];
		logic [4:0] flink[NSLOT];
		logic [4:0] ftop, qhead, qtail;
		logic [4:0] qnext[NSLOT];
		logic [4:0] qprev[NSLOT];
		result_t pending[$];
		int errors;

		function new();
			init_to = 32'd0; step = 32'd0; cap = 32'd0; dbl = 1'b0; limit = 8'd0;
			for (int i = 0; i < NSLOT; i++) begin
				busy[i] = 1'b0;
				flink[i] = 5'(i + 1);
			end
			ftop = 5'd0; qhead = NONE; qtail = NONE;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				CFG_INIT_TO: init_to = v;
				CFG_STEP: step = v;
				CFG_DOUBLE: dbl = v[0];
				CFG_CAP: cap = v;
				CFG_LIMIT: limit = v[7:0];
				default: ;
			endcase
		endfunction

		function void free_slot(int s);
			if (qprev[s] != NONE) qnext[qprev[s]] = qnext[s]; else qhead = qnext[s];
			if (qnext[s] != NONE) qprev[qnext[s]] = qprev[s]; else qtail = qprev[s];
			busy[s] = 1'b0;
			flink[s] = ftop;
			ftop = 5'(s);
		endfunction

		function void note_input(logic [55:0] d);
			op_t op;
			logic [31:0] id;
			logic [15:0] bl;
			int ix, s, n;
			logic [32:0] sum;
			logic [31:0] t;
			result_t r;
			op = op_t'(d[1:0]);
			id = d[33:2];
			bl = d[49:34];
			ix = int'(d[53:50]);
			r = '0;
			if (op == OP_ALLOC) begin
				if (ftop == NONE) r.status = ST_FULL;
				else begin
					s = int'(ftop);
					ftop = flink[s];
					busy[s] = 1'b1; rid[s] = id; len[s] = bl; tmo[s] = init_to;
					answered[s] = 1'b0; retries[s] = 8'd0;
					qprev[s] = qtail; qnext[s] = NONE;
					if (qtail != NONE) qnext[qtail] = 5'(s); else qhead = 5'(s);
					qtail = 5'(s);
					r.status = ST_GRANTED; r.slot = 4'(s); r.timeout = init_to;
				end
			end else if (op == OP_REPLY) begin
				s = int'(qhead); n = 0;
				while (s != int'(NONE) && n < NSLOT && rid[s] != id) begin
					s = int'(qnext[s]);
					n++;
				end
				if (s == int'(NONE) || n >= NSLOT) r.status = ST_UNKNOWN;
				else if (answered[s]) begin
					r.status = ST_DUP; r.slot = 4'(s);
				end else begin
					answered[s] = 1'b1;
					r.status = ST_MATCHED; r.slot = 4'(s); r.length = len[s];
				end
			end else if (!busy[ix]) r.status = ST_NOT_BUSY;
			else if (op == OP_TIMEOUT) begin
				sum = dbl ? {tmo[ix], 1'b0} : {1'b0, tmo[ix]} + {1'b0, step};
				t = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				if (cap != 32'd0 && t >= cap) t = cap;
				tmo[ix] = t;
				r.status = ST_RETRY; r.slot = 4'(ix); r.timeout = t;
				if (limit != 8'd0) begin
					retries[ix] = retries[ix] + 8'd1;
					if (retries[ix] >= limit) begin
						free_slot(ix);
						r.status = ST_GAVE_UP; r.timeout = 32'd0;
					end
				end
			end else begin
				free_slot(ix);
				r.status = ST_RELEASED; r.slot = 4'(ix);
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [55:0] d);
			result_t e, a;
			a = {status_t'(d[3:0]), d[7:4], d[23:8], d[55:24]};
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.status != a.status || e.slot != a.slot || e.length != a.length ||
				e.timeout != a.timeout) begin
				$display("%0t: expected st=%0d slot=%0d len=%h to=%h,",
					$time, e.status, e.slot, e.length, e.timeout,
					" got st=%0d slot=%0d len=%h to=%h",
					a.status, a.slot, a.length, a.timeout);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [55:0] m_axis_tdata;
	logic cfg_we = 0;
	logic [2:0] cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;

	slot_table_scoreboard sb;
	int src_idle = 0, sink_idle = 0;
	bit sink_hold = 0;
	int quiet = 0;
	logic [31:0] ids[$];

	request_slot_match_table_unit #(.SLOTS(NSLOT)) uut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle);
		end
	end

	always @(posedge clk) begin
		if (quiet > 5000) begin
			$display("request_slot_match_table_unit: mismatch");
			$finish;
		end
	end

	task automatic send(op_t op, logic [31:0] id, logic [15:0] bl, logic [3:0] ix);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b0, ix, bl, id, op};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic configure(logic [31:0] it, logic [31:0] st, logic d, logic [31:0] c,
			logic [7:0] l);
		settle();
		write_reg(CFG_INIT_TO, it);
		write_reg(CFG_STEP, st);
		write_reg(CFG_DOUBLE, {31'b0, d});
		write_reg(CFG_CAP, c);
		write_reg(CFG_LIMIT, {24'b0, l});
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int k;
		logic [31:0] id;
		k = int'($urandom_range(99));
		if (k < 35) begin
			id = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(7));
			ids.push_back(id);
			send(OP_ALLOC, id, 16'($urandom), 4'($urandom));
		end else if (k < 60) begin
			id = (ids.size() > 0 && $urandom_range(3) != 0) ?
				ids[$urandom_range(ids.size() - 1)] : $urandom;
			send(OP_REPLY, id, 16'($urandom), 4'($urandom));
		end else if (k < 85)
			send(OP_TIMEOUT, $urandom, 16'($urandom), 4'($urandom));
		else
			send(OP_RELEASE, $urandom, 16'($urandom), 4'($urandom));
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		configure(32'd100, 32'd7, 1'b0, 32'd0, 8'd0);
		send(OP_REPLY, 32'd5, 16'd0, 4'd0);
		send(OP_TIMEOUT, 32'd0, 16'd0, 4'd3);
		for (int i = 0; i < NSLOT; i++)
			send(OP_ALLOC, (i == 15) ? 32'hFFFF_FFFF : 32'(i % 3), 16'hFFFF - 16'(i), 4'hF);
		send(OP_ALLOC, 32'd9, 16'd1, 4'd0);
		send(OP_REPLY, 32'd1, 16'd0, 4'd0);
		send(OP_REPLY, 32'd1, 16'd0, 4'd0);
		send(OP_REPLY, 32'hFFFF_FFFF, 16'd0, 4'd0);
		send(OP_TIMEOUT, 32'd0, 16'd0, 4'd1);
		send(OP_RELEASE, 32'd0, 16'd0, 4'd1);
		send(OP_RELEASE, 32'd0, 16'd0, 4'd1);
		configure(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 8'd255);
		send(OP_TIMEOUT, 32'd0, 16'd0, 4'd2);
		configure(32'h8000_0000, 32'd0, 1'b1, 32'd0, 8'd1);
		send(OP_TIMEOUT, 32'd0, 16'd0, 4'd4);
		configure(32'd1, 32'd0, 1'b1, 32'd50, 8'd3);

		src_idle = 8; sink_idle = 78;
		repeat (170) random_item();
		configure(32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0, 8'd255);
		fork
			begin
				sink_hold = 1;
				repeat (300) @(posedge clk);
				sink_hold = 0;
			end
			begin
				repeat (20) random_item();
				s_axis_tvalid <= 1'b0;
			end
		join
		configure(32'd3, 32'h4000_0000, 1'b0, 32'hC000_0000, 8'd0);
		src_idle = 78; sink_idle = 8;
		repeat (150) random_item();
		configure(32'd0, 32'd1, 1'b1, 32'd0, 8'd2);
		src_idle = 0; sink_idle = 0;
		repeat (160) random_item();
		settle();
		if (sb.errors == 0)
			$display("request_slot_match_table_unit: match");
		else
			$display("request_slot_match_table_unit: mismatch");
		$finish;
	end
endmodule
